FILE: rtl/core/pae_ptw_pkg.sv
// ----------------------------------------------------------------------------
// PAE page table walker package
// Shared types, constants, codes and entry masks for the walker.
// ----------------------------------------------------------------------------
package pae_ptw_pkg;

    // Physical address width held by table entry frames.
    localparam int PHYS_ADDR_BITS = 48;

    // Field widths of the interface.
    localparam int ADDR_W  = 48;
    localparam int VADDR_W = 32;
    localparam int ENTRY_W = 64;

    // Entry masks; the address, frame and reserved-bit masks are derived from the physical address width.
    localparam logic [63:0] ADDR_MASK  = (64'd1 << PHYS_ADDR_BITS) - 64'd1;
    localparam logic [63:0] FRAME_MASK = ADDR_MASK & ~64'hfff;
    localparam logic [63:0] PDPT_RSVD  = 64'h1e6 | ~ADDR_MASK;
    localparam logic [63:0] LOWER_RSVD = ((64'd1 << 52) - 64'd1) & ~ADDR_MASK;
    localparam logic [63:0] PDPT_OFFS  = 64'hfe0;
    localparam logic [63:0] LOW_4K     = 64'h0000_0000_0000_0fff;
    localparam logic [63:0] LOW_2M     = 64'h0000_0000_001f_ffff;

    // Entry bit positions.
    localparam int BIT_PRESENT = 0;
    localparam int BIT_USER    = 2;
    localparam int BIT_PS      = 7;

    // Table levels.
    localparam logic [1:0] LVL_NONE = 2'd0;
    localparam logic [1:0] LVL_PT   = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PDPT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TABLE_BASE  = 2'd0;
    localparam logic [1:0] CFG_USER_ONLY   = 2'd1;
    localparam logic [1:0] CFG_START_LEVEL = 2'd2;

    // Input transaction kinds.
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_RESPONSE  = 1'b1;

    // Result kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // Walk status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_PRESENT = 3'd1,
        ST_RESERVED    = 3'd2,
        ST_SUPERVISOR  = 3'd3,
        ST_READ_FAULT  = 3'd4
    } status_t;

    // Configuration seen by the walk logic.
    typedef struct packed {
        logic [ADDR_W-1:0] table_base;
        logic              user_only;
        logic [1:0]        start_level;
    } cfg_t;

    // One input transaction.
    typedef struct packed {
        logic               req_type;
        logic [VADDR_W-1:0] vaddr;
        logic [ENTRY_W-1:0] read_data;
        logic               read_fault;
    } item_t;

    // Walk state.
    typedef struct packed {
        logic               busy;
        logic [1:0]         cur_level;
        logic [VADDR_W-1:0] saved_vaddr;
    } walk_t;

    // One result transaction.
    typedef struct packed {
        logic               out_kind;
        logic [ADDR_W-1:0]  read_addr;
        logic [ADDR_W-1:0]  phys_addr;
        status_t            status;
        logic [ENTRY_W-1:0] raw_entry;
    } result_t;

endpackage

FILE: rtl/core/pae_page_table_walker.sv
// ----------------------------------------------------------------------------
// PAE page table walker
// Three-level x86 PAE table walk, one input transaction per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries both translate requests
//   and table read responses, marked by req_type. Each accepted transaction
//   gives at most one result on the output channel (out_valid / out_stall):
//   either a table read request (out_kind 0, read_addr) or a final result
//   (out_kind 1, phys_addr, status, raw_entry). Requests while a walk is in
//   progress and responses while idle give no result.
//   A transaction accepted at one clock edge is registered in the input
//   register and evaluated by the step logic, and its result is written to
//   the result register once that register is free or being emptied. One
//   transaction is accepted every cycle while the receiver does not stall;
//   the rate is set by the single evaluation stage between the input and result registers.
//   When the receiver stalls, the result register holds; once the input
//   register also holds a transaction, in_stall is raised until the result
//   is taken.
//   The configuration channel (cfg_valid / cfg_ready) is always ready and
//   should be written only while no transaction is in flight.
//   Reset clears all valid flags and walk state and restores table_base 0,
//   user_only 0 and start_level 3.
// ----------------------------------------------------------------------------
module pae_page_table_walker
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [31:0]                     vaddr,
    input  logic [63:0]                     read_data,
    input  logic                            read_fault,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            out_kind,
    output logic [pae_ptw_pkg::ADDR_W-1:0]  read_addr,
    output logic [pae_ptw_pkg::ADDR_W-1:0]  phys_addr,
    output logic [2:0]                      status,
    output logic [63:0]                     raw_entry,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [pae_ptw_pkg::ADDR_W-1:0]  cfg_data
);

    pae_ptw_pkg::cfg_t     cfg;
    pae_ptw_pkg::item_t    item_reg;
    pae_ptw_pkg::item_t    item_next;
    logic                  item_vld_reg;
    logic                  item_vld_next;
    pae_ptw_pkg::walk_t    walk_reg;
    pae_ptw_pkg::walk_t    walk_next;
    pae_ptw_pkg::walk_t    walk_step;
    pae_ptw_pkg::result_t  res_reg;
    pae_ptw_pkg::result_t  res_next;
    pae_ptw_pkg::result_t  res_step;
    logic                  res_vld_reg;
    logic                  res_vld_next;
    logic                  emit;
    logic                  advance;
    logic                  in_take;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    pae_ptw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Walk evaluation for the registered transaction.
    pae_ptw_step u_step
    (
        .item      (item_reg),
        .walk      (walk_reg),
        .cfg       (cfg),
        .emit      (emit),
        .result    (res_step),
        .walk_next (walk_step)
    );

    // The stage moves on when the result register is free or being emptied.
    assign advance  = !res_vld_reg || !out_stall;
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_comb
    begin
        item_next.req_type   = req_type;
        item_next.vaddr      = vaddr;
        item_next.read_data  = read_data;
        item_next.read_fault = read_fault;
        if (in_take)
        begin
            item_vld_next = 1'b1;
        end
        else if (advance)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end
    end

    // Walk state and result register.
    always_comb
    begin
        walk_next    = walk_reg;
        res_next     = res_reg;
        res_vld_next = res_vld_reg;
        if (advance)
        begin
            res_vld_next = item_vld_reg && emit;
            if (item_vld_reg)
            begin
                walk_next = walk_step;
                res_next  = res_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            walk_reg     <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
            walk_reg     <= walk_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= item_next;
        end
        res_reg <= res_next;
    end

    // Result ports.
    assign out_valid = res_vld_reg;
    assign out_kind  = res_reg.out_kind;
    assign read_addr = res_reg.read_addr;
    assign phys_addr = res_reg.phys_addr;
    assign status    = res_reg.status;
    assign raw_entry = res_reg.raw_entry;

endmodule

FILE: rtl/core/pae_ptw_cfg.sv
// ----------------------------------------------------------------------------
// PAE page table walker configuration registers
// Holds table base, user-only flag and start level, written by index.
// ----------------------------------------------------------------------------
module pae_ptw_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_index,
    input  logic [pae_ptw_pkg::ADDR_W-1:0]  cfg_data,
    output pae_ptw_pkg::cfg_t               cfg
);

    pae_ptw_pkg::cfg_t cfg_reg;
    pae_ptw_pkg::cfg_t cfg_next;

    // Decode a write; an index beyond the list changes nothing.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pae_ptw_pkg::CFG_TABLE_BASE:  cfg_next.table_base  = cfg_data;
                pae_ptw_pkg::CFG_USER_ONLY:   cfg_next.user_only   = cfg_data[0];
                pae_ptw_pkg::CFG_START_LEVEL: cfg_next.start_level = cfg_data[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.table_base  <= '0;
            cfg_reg.user_only   <= 1'b0;
            cfg_reg.start_level <= pae_ptw_pkg::LVL_PDPT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/pae_ptw_step.sv
// ----------------------------------------------------------------------------
// PAE page table walker step logic
// Works out the result and the next walk state for one input transaction.
// ----------------------------------------------------------------------------
module pae_ptw_step
(
    input  pae_ptw_pkg::item_t    item,
    input  pae_ptw_pkg::walk_t    walk,
    input  pae_ptw_pkg::cfg_t     cfg,
    output logic                  emit,
    output pae_ptw_pkg::result_t  result,
    output pae_ptw_pkg::walk_t    walk_next
);

    logic [1:0]  req_level;
    logic [1:0]  rsp_level;
    logic [63:0] base_sel;
    logic [1:0]  addr_level;
    logic [8:0]  idx;
    logic [63:0] entry_sum;
    logic [63:0] pte;
    logic [63:0] low_mask;
    logic [63:0] va_ext;
    logic [63:0] pa_full;

    assign pte    = item.read_data;
    assign va_ext = {32'd0, walk.saved_vaddr};

    // Level of the top table for a new request; zero means the PAE default.
    assign req_level = (cfg.start_level == pae_ptw_pkg::LVL_NONE) ?
                       pae_ptw_pkg::LVL_PDPT : cfg.start_level;

    // Level of the entry that has just come back.
    assign rsp_level = (walk.cur_level == pae_ptw_pkg::LVL_NONE) ?
                       pae_ptw_pkg::LVL_PT : walk.cur_level;

    // Base and level for the next entry address.
    always_comb
    begin
        if (item.req_type == pae_ptw_pkg::REQ_TRANSLATE)
        begin
            base_sel   = {16'd0, cfg.table_base};
            addr_level = req_level;
        end
        else
        begin
            base_sel   = pte;
            addr_level = (rsp_level == pae_ptw_pkg::LVL_PDPT) ?
                         pae_ptw_pkg::LVL_PD : pae_ptw_pkg::LVL_PT;
        end
    end

    // Table index taken from the virtual address for that level.
    always_comb
    begin
        logic [31:0] va_sel;
        va_sel = (item.req_type == pae_ptw_pkg::REQ_TRANSLATE) ?
                 item.vaddr : walk.saved_vaddr;
        case (addr_level)
            pae_ptw_pkg::LVL_PDPT: idx = {7'd0, va_sel[31:30]};
            pae_ptw_pkg::LVL_PD:   idx = va_sel[29:21];
            pae_ptw_pkg::LVL_PT:   idx = va_sel[20:12];
            default:               idx = va_sel[8:0];
        endcase
    end

    // Entry address: frame, PDPT offset at the top level, then the index.
    always_comb
    begin
        entry_sum = (base_sel & pae_ptw_pkg::FRAME_MASK) + {52'd0, idx, 3'd0};
        if (addr_level == pae_ptw_pkg::LVL_PDPT)
        begin
            entry_sum = entry_sum + (base_sel & pae_ptw_pkg::PDPT_OFFS);
        end
    end

    // Final address for a 4 KB or 2 MB page.
    assign low_mask = (rsp_level == pae_ptw_pkg::LVL_PT) ?
                      pae_ptw_pkg::LOW_4K : pae_ptw_pkg::LOW_2M;
    assign pa_full  = (pte & pae_ptw_pkg::FRAME_MASK & ~low_mask) | (va_ext & low_mask);

    // Decision for this transaction, checks in walk order.
    always_comb
    begin
        emit             = 1'b0;
        walk_next        = walk;
        result.out_kind  = pae_ptw_pkg::KIND_FINAL;
        result.read_addr = '0;
        result.phys_addr = '0;
        result.status    = pae_ptw_pkg::ST_OK;
        result.raw_entry = '0;

        if (item.req_type == pae_ptw_pkg::REQ_TRANSLATE)
        begin
            // A request is taken only when no walk is in progress.
            if (!walk.busy)
            begin
                emit                  = 1'b1;
                walk_next.busy        = 1'b1;
                walk_next.cur_level   = req_level;
                walk_next.saved_vaddr = item.vaddr;
                result.out_kind       = pae_ptw_pkg::KIND_READ;
                result.read_addr      = entry_sum[pae_ptw_pkg::ADDR_W-1:0];
            end
        end
        else if (walk.busy)
        begin
            emit           = 1'b1;
            walk_next.busy = 1'b0;
            if (item.read_fault)
            begin
                result.status = pae_ptw_pkg::ST_READ_FAULT;
            end
            else if (!pte[pae_ptw_pkg::BIT_PRESENT])
            begin
                result.status = pae_ptw_pkg::ST_NOT_PRESENT;
                if (rsp_level == pae_ptw_pkg::LVL_PT)
                begin
                    result.raw_entry = pte;
                end
            end
            else if (rsp_level == pae_ptw_pkg::LVL_PDPT)
            begin
                // The PDPT has its own reserved bits and no user check.
                if ((pte & pae_ptw_pkg::PDPT_RSVD) != 64'd0)
                begin
                    result.status = pae_ptw_pkg::ST_RESERVED;
                end
                else
                begin
                    walk_next.busy      = 1'b1;
                    walk_next.cur_level = pae_ptw_pkg::LVL_PD;
                    result.out_kind     = pae_ptw_pkg::KIND_READ;
                    result.read_addr    = entry_sum[pae_ptw_pkg::ADDR_W-1:0];
                end
            end
            else if (cfg.user_only && !pte[pae_ptw_pkg::BIT_USER])
            begin
                result.status = pae_ptw_pkg::ST_SUPERVISOR;
            end
            else if ((pte & pae_ptw_pkg::LOWER_RSVD) != 64'd0)
            begin
                result.status = pae_ptw_pkg::ST_RESERVED;
            end
            else if (rsp_level == pae_ptw_pkg::LVL_PT || pte[pae_ptw_pkg::BIT_PS])
            begin
                result.phys_addr = pa_full[pae_ptw_pkg::ADDR_W-1:0];
            end
            else
            begin
                walk_next.busy      = 1'b1;
                walk_next.cur_level = pae_ptw_pkg::LVL_PT;
                result.out_kind     = pae_ptw_pkg::KIND_READ;
                result.read_addr    = entry_sum[pae_ptw_pkg::ADDR_W-1:0];
            end
        end
    end

endmodule
